// ----- design/srm_pkg.sv -----
// shared constants and types for the sorted run merger
// no dependencies; used by the top level, loader, merge unit and bench
`default_nettype none

package srm_pkg;

    localparam int RUN_DEPTH = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);

    // run fill status handed from the loader to the merge unit
    typedef struct packed {
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic             overflow;
    } srm_status_t;

endpackage

`default_nettype wire

// ----- design/sorted_run_merger_top.sv -----
// sorted run merger: loads two ascending runs, then emits their stable merge
// after tlast is taken: ST_PRIME, ST_MERGE, then the first merged word is registered
// throughput: one loaded word per cycle; one merged word per cycle while m_tready is high,
//   set by the one read port of each run memory; s_tready is low from tlast to last result
// reset: counts, overflow flag, state and output valid clear; run memories are not cleared
// depends on srm_pkg, srm_ram, srm_loader, srm_merge
`default_nettype none

module sorted_run_merger_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element
    input  wire logic [1:0]  s_tuser,   // [0] run_select, [1] carries_element
    input  wire logic        s_tlast,   // final_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] merged_value
    output logic             m_tuser,   // [0] overflowed
    output logic             m_tlast    // last_of_run
);

    srm_pkg::srm_status_t          status;
    logic                          accept;
    logic                          we_a, we_b;
    logic [srm_pkg::ADDR_W-1:0]    waddr_a, waddr_b;
    logic [srm_pkg::ADDR_W-1:0]    raddr_a, raddr_b;
    logic [srm_pkg::DATA_W-1:0]    rdata_a, rdata_b;
    logic                          start;
    logic                          clear;
    logic                          idle;

    assign s_tready = idle;
    assign accept   = s_tvalid && idle;

    srm_loader u_loader (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .run_select      (s_tuser[0]),
        .carries_element (s_tuser[1]),
        .final_item      (s_tlast),
        .clear           (clear),
        .we_a            (we_a),
        .we_b            (we_b),
        .waddr_a         (waddr_a),
        .waddr_b         (waddr_b),
        .start           (start),
        .status          (status)
    );

    srm_ram #(
        .WIDTH (srm_pkg::DATA_W),
        .DEPTH (srm_pkg::RUN_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (s_tdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    srm_ram #(
        .WIDTH (srm_pkg::DATA_W),
        .DEPTH (srm_pkg::RUN_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (s_tdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    srm_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b),
        .raddr_a  (raddr_a),
        .raddr_b  (raddr_b),
        .clear    (clear),
        .idle     (idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- design/srm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module srm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/srm_loader.sv -----
// loader: appends input words to the two run memories, keeps counts and overflow
// depends on srm_pkg
`default_nettype none

module srm_loader (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      run_select,
    input  wire logic                      carries_element,
    input  wire logic                      final_item,
    input  wire logic                      clear,
    output logic                           we_a,
    output logic                           we_b,
    output logic [srm_pkg::ADDR_W-1:0]     waddr_a,
    output logic [srm_pkg::ADDR_W-1:0]     waddr_b,
    output logic                           start,
    output srm_pkg::srm_status_t           status
);

    logic [srm_pkg::CNT_W-1:0] count_a_reg, count_a_next;
    logic [srm_pkg::CNT_W-1:0] count_b_reg, count_b_next;
    logic                      overflow_reg, overflow_next;
    logic                      full_a, full_b;

    assign full_a = (count_a_reg == srm_pkg::CNT_W'(srm_pkg::RUN_DEPTH));
    assign full_b = (count_b_reg == srm_pkg::CNT_W'(srm_pkg::RUN_DEPTH));

    always_comb
    begin
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        overflow_next = overflow_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;
        if (clear)
        begin
            count_a_next  = '0;
            count_b_next  = '0;
            overflow_next = 1'b0;
        end
        else if (accept && carries_element)
        begin
            if (!run_select)
            begin
                if (full_a)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    we_a         = 1'b1;
                    count_a_next = count_a_reg + 1'b1;
                end
            end
            else
            begin
                if (full_b)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    we_b         = 1'b1;
                    count_b_next = count_b_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            overflow_reg <= overflow_next;
        end
    end

    assign waddr_a         = count_a_reg[srm_pkg::ADDR_W-1:0];
    assign waddr_b         = count_b_reg[srm_pkg::ADDR_W-1:0];
    assign start           = accept && final_item;
    assign status.count_a  = count_a_reg;
    assign status.count_b  = count_b_reg;
    assign status.overflow = overflow_reg;

endmodule

`default_nettype wire

// ----- design/srm_merge.sv -----
// merge unit: walks both run memories, emits the stable ascending merge
// depends on srm_pkg; reads the memories through their registered read port
`default_nettype none

module srm_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire srm_pkg::srm_status_t          status,
    input  wire logic [srm_pkg::DATA_W-1:0]    rdata_a,
    input  wire logic [srm_pkg::DATA_W-1:0]    rdata_b,
    output logic      [srm_pkg::ADDR_W-1:0]    raddr_a,
    output logic      [srm_pkg::ADDR_W-1:0]    raddr_b,
    output logic                               clear,
    output logic                               idle,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [srm_pkg::DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MERGE
    } state_t;

    state_t                     state_reg, state_next;
    logic [srm_pkg::CNT_W-1:0]  a_reg, a_next;
    logic [srm_pkg::CNT_W-1:0]  b_reg, b_next;
    logic                       valid_reg, valid_next;
    logic [srm_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       last_reg, last_next;
    logic                       ovf_reg, ovf_next;
    logic                       slot_free;
    logic                       take_a;

    assign slot_free = !valid_reg || m_tready;

    // stable pick: first run wins on equal values
    assign take_a = (a_reg < status.count_a) &&
                    ((b_reg >= status.count_b) ||
                     ($signed(rdata_a) <= $signed(rdata_b)));

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        clear      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                // memories now show entry zero of each run
                if (status.count_a == '0 && status.count_b == '0)
                begin
                    clear      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (slot_free)
                begin
                    if (take_a)
                    begin
                        a_next    = a_reg + 1'b1;
                        data_next = rdata_a;
                    end
                    else
                    begin
                        b_next    = b_reg + 1'b1;
                        data_next = rdata_b;
                    end
                    valid_next = 1'b1;
                    ovf_next   = status.overflow;
                    last_next  = (a_next == status.count_a) && (b_next == status.count_b);
                    if (last_next)
                    begin
                        clear      = 1'b1;
                        a_next     = '0;
                        b_next     = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            valid_reg <= 1'b0;
            data_reg  <= '0;
            last_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            valid_reg <= valid_next;
            data_reg  <= data_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
        end
    end

    // read the head the next cycle will compare
    assign raddr_a  = a_next[srm_pkg::ADDR_W-1:0];
    assign raddr_b  = b_next[srm_pkg::ADDR_W-1:0];
    assign idle     = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

endmodule

`default_nettype wire

// ----- design/srm_checker.sv -----
// port-level checks for the sorted run merger, bound to the top level
// depends on sorted_run_merger_top
`default_nettype none

module srm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

    // a merge starts on tlast, so loading stops
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still ready after final word");

    // plain load words keep the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("input closed after a load word");

    // while a merge is unfinished no loading takes place
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a merge");

    // overflow flag is the same on consecutive words of one merge
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser == $past(m_tuser))
    else $error("overflow flag changed within a merge");

endmodule

bind sorted_run_merger_top srm_checker u_srm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/tb_sorted_run_merger_top.sv -----
// self-checking bench for sorted_run_merger_top: directed table, then random batches of runs
// each merge is predicted in-bench and every merged word is compared in order
// depends on srm_pkg and the sorted_run_merger_top design files
`default_nettype none

module tb_sorted_run_merger_top;

    localparam int ITEMS_PER_PHASE = 115;
    localparam int QUIET_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 24;
    localparam int DIR_ROWS        = 22;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {VALS_TIES, VALS_EDGES, VALS_WIDE} val_mode_t;

    // one loaded word; typed rows carry their single merged word in exp_*
    typedef struct packed {
        logic                             sel;
        logic signed [srm_pkg::DATA_W-1:0] elem;
        logic                             carries;
        logic                             fin;
        logic                             typed;
        logic signed [srm_pkg::DATA_W-1:0] exp_value;
        logic                             exp_ovf;
    } in_word_t;

    typedef struct packed {
        logic signed [srm_pkg::DATA_W-1:0] value;
        logic                             last;
        logic                             ovf;
    } merged_word_t;

    typedef logic signed [srm_pkg::DATA_W-1:0] val_q_t[$];

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sorted_run_merger_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // directed table: sel, element, carries, final, typed, expected value, expected overflow
    in_word_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 32'sh7fff_ffff, 1'b1, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b0},
        '{1'b1, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 32'sh8000_0000, 1'b0},
        '{1'b0, 32'shdead_beef, 1'b0, 1'b1, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sh0000_0000, 1'b1, 1'b1, 1'b1, 32'sh0000_0000, 1'b0},
        '{1'b1, 32'shffff_ffff, 1'b1, 1'b1, 1'b1, 32'shffff_ffff, 1'b0},
        '{1'b0, -32'sd5,        1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, -32'sd5,        1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sd3,         1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sh5555_aaaa, 1'b0, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sd10,        1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sh0000_1234, 1'b0, 1'b1, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sd9,         1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sd1,         1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sd5,         1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sd2,         1'b1, 1'b1, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'shaaaa_5555, 1'b0, 1'b1, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b0, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{1'b1, 32'sh7fff_ffff, 1'b1, 1'b1, 1'b0, 32'sh0,         1'b0}
    };

    in_word_t                          word_q[$];
    merged_word_t                      expected_q[$];
    logic signed [srm_pkg::DATA_W-1:0] run_a[$];
    logic signed [srm_pkg::DATA_W-1:0] run_b[$];
    logic                              batch_ovf   = 1'b0;
    in_word_t                          cur_word;
    idle_mode_t                        idle_mode   = IDLE_NONE;
    int                                calm_left   = 0;
    int                                quiet_cycles = 0;
    int                                err_cnt     = 0;

    // fold one accepted word into the runs; a final word queues the merged words
    function automatic void absorb_word(input in_word_t w);
        merged_word_t r;
        int ia;
        int ib;
        int total;
        if (w.carries)
        begin
            if (w.sel == 1'b0)
            begin
                if (run_a.size() < srm_pkg::RUN_DEPTH) run_a.push_back(w.elem);
                else batch_ovf = 1'b1;
            end
            else
            begin
                if (run_b.size() < srm_pkg::RUN_DEPTH) run_b.push_back(w.elem);
                else batch_ovf = 1'b1;
            end
        end
        if (w.fin)
        begin
            if (w.typed)
            begin
                r.value = w.exp_value;
                r.last  = 1'b1;
                r.ovf   = w.exp_ovf;
                expected_q.push_back(r);
            end
            else
            begin
                total = run_a.size() + run_b.size();
                ia = 0;
                ib = 0;
                for (int k = 0; k < total; k++)
                begin
                    // ties go to the first run
                    if (ia < run_a.size() && (ib >= run_b.size() || run_a[ia] <= run_b[ib]))
                    begin
                        r.value = run_a[ia];
                        ia++;
                    end
                    else
                    begin
                        r.value = run_b[ib];
                        ib++;
                    end
                    r.last = (k == total - 1);
                    r.ovf  = batch_ovf;
                    expected_q.push_back(r);
                end
            end
            run_a.delete();
            run_b.delete();
            batch_ovf = 1'b0;
        end
    endfunction

    function automatic bit sender_idles();
        if (calm_left > 0) return 1'b0;
        if (idle_mode == IDLE_SEND) return $urandom_range(0, 99) < 66;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 35;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (calm_left > 0) return 1'b0;
        if (idle_mode == IDLE_RECV) return $urandom_range(0, 99) < 66;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 35;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin : drive_and_check
        merged_word_t got;
        merged_word_t want;
        logic         offering;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (m_tvalid && m_tready)
            begin
                moved     = 1'b1;
                got.value = m_tdata;
                got.last  = m_tlast;
                got.ovf   = m_tuser;
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected merged word value=%h last=%b ovf=%b",
                             $time, got.value, got.last, got.ovf);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        $display("%0t: exp value=%h last=%b ovf=%b got value=%h last=%b ovf=%b",
                                 $time, want.value, want.last, want.ovf,
                                 got.value, got.last, got.ovf);
                    end
                end
            end

            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                moved    = 1'b1;
                offering = 1'b0;
                absorb_word(cur_word);
            end
            if (!offering)
            begin
                if (word_q.size() != 0 && !sender_idles())
                begin
                    cur_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.elem;
                    s_tuser  <= {cur_word.carries, cur_word.sel};
                    s_tlast  <= cur_word.fin;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end

            m_tready <= !receiver_stalls();

            // occasional stretches with no idling on either side
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(16, 48);

            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    function automatic logic signed [srm_pkg::DATA_W-1:0] pick_value(input val_mode_t mode);
        case (mode)
            VALS_TIES:  return $urandom_range(0, 6) - 3;
            VALS_EDGES: return $urandom_range(0, 1) ? 32'sh7fff_fff8 + $urandom_range(0, 7)
                                                   : 32'sh8000_0000 + $urandom_range(0, 7);
            default:    return $urandom;
        endcase
    endfunction

    task automatic build_run(input int len, input val_mode_t mode, input bit ordered,
                             output val_q_t run);
        logic signed [srm_pkg::DATA_W-1:0] v;
        int p;
        run = {};
        for (int i = 0; i < len; i++)
        begin
            v = pick_value(mode);
            p = run.size();
            while (ordered && p > 0 && run[p-1] > v) p--;
            run.insert(p, v);
        end
    endtask

    // one batch of loads ending in a final word; counted skips ignored marker words but counts a marker-only final word
    task automatic queue_batch(input bit go_big, output int counted);
        val_q_t    va;
        val_q_t    vb;
        int        len_a;
        int        len_b;
        int        pick;
        int        ia;
        int        ib;
        bit        ordered;
        bit        side;
        val_mode_t mode;
        in_word_t  w;
        pick = $urandom_range(0, 99);
        if (go_big || pick < 8)
        begin
            len_a = go_big ? 36 : $urandom_range(28, 40);
            len_b = $urandom_range(28, 40);
        end
        else if (pick < 14)
        begin
            len_a = 0;
            len_b = 0;
        end
        else
        begin
            len_a = $urandom_range(0, 6);
            len_b = $urandom_range(0, 6);
        end
        mode    = val_mode_t'($urandom_range(0, 2));
        ordered = ($urandom_range(0, 9) != 0);
        build_run(len_a, mode, ordered, va);
        build_run(len_b, mode, ordered, vb);
        counted = 0;
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w      = '0;
                w.sel  = 1'($urandom_range(0, 1));
                w.elem = $urandom;
                word_q.push_back(w);
            end
            if (ia >= len_a) side = 1'b1;
            else if (ib >= len_b) side = 1'b0;
            else side = 1'($urandom_range(0, 1));
            w         = '0;
            w.sel     = side;
            w.carries = 1'b1;
            if (side)
            begin
                w.elem = vb[ib];
                ib++;
            end
            else
            begin
                w.elem = va[ia];
                ia++;
            end
            word_q.push_back(w);
            counted++;
        end
        if (counted != 0 && $urandom_range(0, 1))
        begin
            word_q[word_q.size()-1].fin = 1'b1;
        end
        else
        begin
            // marker-only final word
            w      = '0;
            w.sel  = 1'($urandom_range(0, 1));
            w.elem = $urandom;
            w.fin  = 1'b1;
            word_q.push_back(w);
            counted++;
        end
    endtask

    // sender holds off until every expected merged word has come back
    task automatic drain();
        while (word_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_mode = IDLE_NONE;
        foreach (dir_tab[i]) word_q.push_back(dir_tab[i]);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = idle_mode_t'(ph);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                queue_batch(ph == 0 && sent == 0, n);
                sent += n;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
